@@ rtl/vlcp_pkg.sv @@
// Shared constants, codes and types for the variable-length code chunk packer.
`timescale 1ns / 1ps

package vlcp_pkg;

    // Field widths fixed by the item format.
    localparam int MODE_W  = 1;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int FILL_W  = 12;
    localparam int WORD_W  = 64;
    localparam int OFF_W   = 6;
    localparam int SHIFT_W = WORD_W + CODE_W;

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_APPEND = 1'b0;
    localparam logic [MODE_W-1:0] MODE_FINISH = 1'b1;

    // Result item kinds.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // One input item as held in the input register.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CODE_W-1:0] code_value;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    // One result item as held in the output register.
    typedef struct packed {
        logic              kind;
        logic [FILL_W-1:0] used_bits;
        logic [WORD_W-1:0] data_word;
        logic              last;
    } t_out_item;

    // Hand-off of a finished chunk from the packing stage to the emitter.
    typedef struct packed {
        logic              load;
        logic [FILL_W-1:0] fill;
    } t_emit_ctl;

endpackage

@@ rtl/vlcp_in_if.sv @@
// Input channel of the chunk packer: one code or finish request per transaction.
`timescale 1ns / 1ps

interface vlcp_in_if;
    logic                        valid;
    logic                        ready;
    logic [vlcp_pkg::MODE_W-1:0] mode;
    logic [vlcp_pkg::CODE_W-1:0] code_value;
    logic [vlcp_pkg::LEN_W-1:0]  code_length;

    modport source (output valid, output mode, output code_value, output code_length,
                    input ready);
    modport sink   (input valid, input mode, input code_value, input code_length,
                    output ready);
endinterface

@@ rtl/vlcp_out_if.sv @@
// Output channel of the chunk packer: one header or data word per transaction.
`timescale 1ns / 1ps

interface vlcp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [vlcp_pkg::FILL_W-1:0] used_bits;
    logic [vlcp_pkg::WORD_W-1:0] data_word;
    logic                        last;

    modport source (output valid, output kind, output used_bits, output data_word,
                    output last, input ready);
    modport sink   (input valid, input kind, input used_bits, input data_word,
                    input last, output ready);
endinterface

@@ rtl/vlcp_emitter.sv @@
// Chunk emitter: holds a snapshot of a finished chunk and sends header and data words.
`timescale 1ns / 1ps

module vlcp_emitter #(
    parameter int CHUNK_WORDS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vlcp_pkg::t_emit_ctl         i_ctl,
    input  logic [vlcp_pkg::WORD_W-1:0] i_chunk [CHUNK_WORDS],
    output logic                        o_busy,
    vlcp_out_if.source                  o_out
);
    import vlcp_pkg::*;

    localparam int CNT_W = $clog2(CHUNK_WORDS + 1);

    logic [WORD_W-1:0] r_snap [CHUNK_WORDS];
    logic [FILL_W-1:0] r_snap_fill;
    logic              r_busy;
    logic              r_hdr;
    logic [CNT_W-1:0]  r_left;
    logic              r_out_valid;
    t_out_item         r_out;
    t_out_item         n_out;
    logic              out_free;
    logic              step;

    // The output register takes a new item when it is empty or being drained.
    assign out_free = !r_out_valid || o_out.ready;
    assign step     = r_busy && out_free;

    // Header first, then the words from the head of the snapshot.
    always_comb begin
        n_out = '0;
        if (r_hdr) begin
            n_out.kind      = KIND_HEADER;
            n_out.used_bits = r_snap_fill;
        end else begin
            n_out.kind      = KIND_DATA;
            n_out.data_word = r_snap[0];
            n_out.last      = (r_left == CNT_W'(1));
        end
    end

    // Snapshot payload: loaded whole, then shifted down one word per data result.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_snap      <= i_chunk;
            r_snap_fill <= i_ctl.fill;
        end else if (step && !r_hdr) begin
            for (int w = 0; w < CHUNK_WORDS - 1; w++) begin
                r_snap[w] <= r_snap[w + 1];
            end
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_hdr       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= step;
            end
            if (i_ctl.load) begin
                r_busy <= 1'b1;
                r_hdr  <= 1'b1;
                r_left <= CNT_W'(CHUNK_WORDS);
            end else if (step) begin
                if (r_hdr) begin
                    r_hdr <= 1'b0;
                end else begin
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_busy          = r_busy;
    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_out.kind;
    assign o_out.used_bits = r_out.used_bits;
    assign o_out.data_word = r_out.data_word;
    assign o_out.last      = r_out.last;

endmodule

@@ rtl/variable_length_code_chunk_packer.sv @@
// Top level of the variable-length code chunk packer.
//
//   port   | direction | transaction
//   -------+-----------+--------------------------------------------------
//   i_in   | sink      | one code (mode, code_value, code_length) or finish
//   o_out  | source    | one chunk header or one 64-bit chunk data word
//
// An input transaction can be taken every cycle unless a flush waits for a busy
// emitter; a code is registered, then merged into the chunk buffer. A flush
// copies the buffer into the emitter, which sends CHUNK_BYTES/8 + 1 results at
// one per cycle, paced by the output port. A second flush waits until that
// emitter is free. Its header passes the input, snapshot and output registers.
// Synchronous active-low reset clears the buffer, the fill count and the emitter.
`timescale 1ns / 1ps

module variable_length_code_chunk_packer #(
    parameter int CHUNK_BYTES  = 32,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vlcp_in_if.sink    i_in,
    vlcp_out_if.source o_out
);
    import vlcp_pkg::*;

    localparam int CHUNK_WORDS = CHUNK_BYTES / 8;
    localparam int CHUNK_BITS  = CHUNK_BYTES * 8;
    localparam int LEN_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int IDX_W       = FILL_W - OFF_W;

    logic              r_in_valid;
    t_in_item          r_in;
    logic [WORD_W-1:0] r_buf [CHUNK_WORDS];
    logic [FILL_W-1:0] r_fill;
    logic [WORD_W-1:0] n_buf [CHUNK_WORDS];
    logic [FILL_W-1:0] n_fill;

    logic               is_finish;
    logic               is_nop;
    logic               do_append;
    logic [LEN_W-1:0]   len_sat;
    logic [CODE_W-1:0]  code_mask;
    logic [CODE_W-1:0]  code_bits;
    logic [FILL_W:0]    fill_sum;
    logic               need_flush;
    logic               proc;
    logic [FILL_W-1:0]  base_fill;
    logic [IDX_W-1:0]   word_idx;
    logic [IDX_W:0]     word_idx_hi;
    logic [OFF_W-1:0]   bit_off;
    logic [SHIFT_W-1:0] shifted;
    logic [FILL_W:0]    base_sum;
    t_emit_ctl          emit_ctl;
    logic               emit_busy;

    // Decode the registered item: saturate the length and mask stray code bits.
    always_comb begin
        is_finish  = (r_in.mode == MODE_FINISH);
        len_sat    = (r_in.code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                            : r_in.code_length;
        is_nop     = !is_finish && (len_sat == '0);
        do_append  = !is_finish && !is_nop;
        code_mask  = CODE_W'((33'(1) << len_sat) - 33'(1));
        code_bits  = r_in.code_value & code_mask;
        fill_sum   = {1'b0, r_fill} + (FILL_W + 1)'(len_sat);
        need_flush = is_finish || (do_append && (fill_sum > (FILL_W + 1)'(CHUNK_BITS)));
    end

    // The item is consumed unless it needs the emitter while that is still busy.
    assign proc       = r_in_valid && (!need_flush || !emit_busy);
    assign i_in.ready = !r_in_valid || proc;

    // Position of the code in the (possibly freshly cleared) buffer.
    always_comb begin
        base_fill   = need_flush ? '0 : r_fill;
        word_idx    = base_fill[FILL_W-1:OFF_W];
        word_idx_hi = {1'b0, word_idx} + (IDX_W + 1)'(1);
        bit_off     = base_fill[OFF_W-1:0];
        shifted     = SHIFT_W'(code_bits) << bit_off;
        base_sum    = {1'b0, base_fill} + (FILL_W + 1)'(len_sat);
        if (is_finish) begin
            n_fill = '0;
        end else if (is_nop) begin
            n_fill = r_fill;
        end else begin
            n_fill = base_sum[FILL_W-1:0];
        end
    end

    // Each buffer word takes the low part, or the spill-over, of the shifted code.
    for (genvar w = 0; w < CHUNK_WORDS; w++) begin : g_lane
        always_comb begin
            n_buf[w] = need_flush ? '0 : r_buf[w];
            if (do_append && (word_idx == IDX_W'(w))) begin
                n_buf[w] = n_buf[w] | shifted[WORD_W-1:0];
            end
            if (do_append && (word_idx_hi == (IDX_W + 1)'(w))) begin
                n_buf[w] = n_buf[w] | WORD_W'(shifted[SHIFT_W-1:WORD_W]);
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.mode        <= i_in.mode;
            r_in.code_value  <= i_in.code_value;
            r_in.code_length <= i_in.code_length;
        end
    end

    // Input valid, chunk buffer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fill     <= '0;
            for (int w = 0; w < CHUNK_WORDS; w++) begin
                r_buf[w] <= '0;
            end
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_buf  <= n_buf;
                r_fill <= n_fill;
            end
        end
    end

    // Hand the current chunk to the emitter on a flush.
    assign emit_ctl.load = proc && need_flush;
    assign emit_ctl.fill = r_fill;

    vlcp_emitter #(
        .CHUNK_WORDS (CHUNK_WORDS)
    ) u_emitter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (emit_ctl),
        .i_chunk (r_buf),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    // A chunk is only handed over to an idle emitter.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.load |-> !emit_busy)
        else $error("chunk handed to a busy emitter");

    // A handed-over chunk keeps the emitter busy in the next cycle.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_ctl.load |=> emit_busy)
        else $error("emitter did not start on a chunk hand-over");

    // The fill count never passes the chunk size.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fill} <= (FILL_W + 1)'(CHUNK_BITS)))
        else $error("fill count beyond chunk size");

    // A finish leaves an empty buffer behind.
    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && is_finish) |=> (r_fill == '0))
        else $error("finish did not clear the fill count");
`endif

endmodule

@@ dv/variable_length_code_chunk_packer_test.sv @@
// Self-checking testbench for the variable-length code chunk packer.
`timescale 1ns / 1ps

module variable_length_code_chunk_packer_test;
    import vlcp_pkg::*;

    localparam int CHUNK_BYTES  = 32;
    localparam int MAX_CODE_LEN = 32;
    localparam int CHUNK_WORDS  = CHUNK_BYTES / 8;
    localparam int CHUNK_BITS   = CHUNK_BYTES * 8;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int RANDOM_CODES = 410;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;
    localparam int MAX_REPORTS  = 10;

    logic i_clk;
    logic i_rst_n = 1'b0;

    vlcp_in_if  code_in ();
    vlcp_out_if word_out ();

    variable_length_code_chunk_packer #(
        .CHUNK_BYTES (CHUNK_BYTES),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (code_in),
        .o_out  (word_out)
    );

    // Testbench-side drive registers, known from time zero.
    logic     drv_valid = 1'b0;
    t_in_item drv_code  = '0;
    logic     sink_ready = 1'b0;
    logic     hold_off   = 1'b0;

    assign code_in.valid       = drv_valid;
    assign code_in.mode        = drv_code.mode;
    assign code_in.code_value  = drv_code.code_value;
    assign code_in.code_length = drv_code.code_length;
    assign word_out.ready      = sink_ready;

    // Shadow packer state and the results it predicts.
    logic [CHUNK_BITS-1:0] pack_buf  = '0;
    logic [FILL_W-1:0]     pack_fill = '0;
    t_out_item             expected_words[$];
    t_in_item              pending_codes[$];

    int codes_accepted  = 0;
    int words_checked   = 0;
    int chunks_seen     = 0;
    int mismatches      = 0;
    int send_wait       = 0;
    int recv_wait       = 0;
    int stall_cycles    = 0;
    int send_draw       = 0;
    int recv_draw       = 0;
    t_out_item got_word;
    t_out_item want_word;

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Wait draw per transaction; every fourth stretch of 40 runs without gaps.
    function automatic int draw_wait(input int n);
        if (((n / 40) % 4) == 3) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic void add_code(input logic [MODE_W-1:0] mode,
                                     input logic [CODE_W-1:0] value,
                                     input logic [LEN_W-1:0] len);
        t_in_item it;
        it.mode        = mode;
        it.code_value  = value;
        it.code_length = len;
        pending_codes.push_back(it);
    endfunction

    // Queue the header and data words of the shadow chunk, then clear it.
    function automatic void emit_expected_chunk();
        t_out_item r;
        r           = '0;
        r.kind      = KIND_HEADER;
        r.used_bits = pack_fill;
        expected_words.push_back(r);
        for (int w = 0; w < CHUNK_WORDS; w++) begin
            r           = '0;
            r.kind      = KIND_DATA;
            r.data_word = pack_buf[w*WORD_W +: WORD_W];
            r.last      = (w == CHUNK_WORDS - 1);
            expected_words.push_back(r);
        end
        pack_buf  = '0;
        pack_fill = '0;
    endfunction

    // Apply one accepted code or finish to the shadow packer.
    function automatic void pack_code(input t_in_item it);
        int                    eff;
        logic [63:0]           mask;
        logic [CHUNK_BITS-1:0] bits;
        if (it.mode == MODE_FINISH) begin
            emit_expected_chunk();
            return;
        end
        eff = it.code_length;
        if (eff > LEN_LIMIT) begin
            eff = LEN_LIMIT;
        end
        if (eff == 0) begin
            return;
        end
        mask              = (64'd1 << eff) - 64'd1;
        bits              = '0;
        bits[CODE_W-1:0]  = it.code_value & mask[CODE_W-1:0];
        if (int'(pack_fill) + eff > CHUNK_BITS) begin
            emit_expected_chunk();
        end
        pack_buf  = pack_buf | (bits << pack_fill);
        pack_fill = pack_fill + FILL_W'(eff);
    endfunction

    // Driver: offers queued codes with a random gap after each transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            send_wait <= 0;
        end else if (drv_valid && code_in.ready) begin
            pack_code(drv_code);
            codes_accepted++;
            send_draw = draw_wait(codes_accepted);
            if (send_draw == 0 && pending_codes.size() > 0) begin
                drv_code <= pending_codes.pop_front();
            end else begin
                drv_valid <= 1'b0;
                send_wait <= (send_draw > 0) ? send_draw - 1 : 0;
            end
        end else if (!drv_valid) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_codes.size() > 0) begin
                drv_code  <= pending_codes.pop_front();
                drv_valid <= 1'b1;
            end
        end
    end

    // Monitor: checks each result transaction and pauses ready at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            recv_wait  <= 0;
        end else begin
            if (word_out.valid && word_out.ready) begin
                got_word.kind      = word_out.kind;
                got_word.used_bits = word_out.used_bits;
                got_word.data_word = word_out.data_word;
                got_word.last      = word_out.last;
                if (got_word.kind == KIND_HEADER) begin
                    chunks_seen++;
                end
                if (expected_words.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: unexpected result kind=%0d used=%0d word=%h last=%0d",
                                 $realtime, got_word.kind, got_word.used_bits,
                                 got_word.data_word, got_word.last);
                    end
                    mismatches++;
                end else begin
                    want_word = expected_words.pop_front();
                    words_checked++;
                    if (got_word.kind !== want_word.kind ||
                        got_word.used_bits !== want_word.used_bits ||
                        got_word.data_word !== want_word.data_word ||
                        got_word.last !== want_word.last) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: mismatch expected kind=%0d used=%0d word=%h last=%0d",
                                     $realtime, want_word.kind, want_word.used_bits,
                                     want_word.data_word, want_word.last);
                            $display("%0t:          actual   kind=%0d used=%0d word=%h last=%0d",
                                     $realtime, got_word.kind, got_word.used_bits,
                                     got_word.data_word, got_word.last);
                        end
                        mismatches++;
                    end
                end
                recv_draw = draw_wait(words_checked + 13);
                sink_ready <= (recv_draw == 0) && !hold_off;
                recv_wait  <= (recv_draw > 0) ? recv_draw - 1 : 0;
            end else if (recv_wait > 0) begin
                sink_ready <= 1'b0;
                recv_wait  <= recv_wait - 1;
            end else begin
                sink_ready <= !hold_off;
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((drv_valid && code_in.ready) || (word_out.valid && word_out.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transaction.", stall_cycles);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Long receiver hold-off so the packer fills up and stalls its input.
    initial begin
        wait (codes_accepted >= HOLD_AFTER);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Stimulus, reset and end of run.
    initial begin
        int made;
        int sel;
        made = 0;

        // Directed: empty finish, zero length, exact fill, overflow, overlong codes.
        add_code(MODE_FINISH, 32'hFFFF_FFFF, 6'd63);
        add_code(MODE_APPEND, 32'hFFFF_FFFF, 6'd0);
        add_code(MODE_APPEND, 32'hFFFF_FFFF, 6'd32);
        add_code(MODE_APPEND, 32'h0000_0000, 6'd32);
        add_code(MODE_APPEND, 32'hA5A5_A5A5, 6'd32);
        add_code(MODE_APPEND, 32'h5A5A_5A5A, 6'd32);
        add_code(MODE_APPEND, 32'h8000_0001, 6'd32);
        add_code(MODE_APPEND, $urandom, 6'd32);
        add_code(MODE_APPEND, $urandom, 6'd32);
        add_code(MODE_APPEND, $urandom, 6'd32);
        add_code(MODE_APPEND, 32'hFFFF_FFFF, 6'd0);
        add_code(MODE_APPEND, 32'hFFFF_FFFF, 6'd1);
        add_code(MODE_FINISH, $urandom, 6'd17);
        add_code(MODE_APPEND, 32'hFFFF_FFFF, 6'd3);
        add_code(MODE_APPEND, $urandom, 6'd63);
        add_code(MODE_APPEND, $urandom, 6'd33);
        add_code(MODE_APPEND, 32'hFFFF_FFFE, 6'd1);
        add_code(MODE_APPEND, $urandom, 6'd40);
        add_code(MODE_FINISH, 32'h0000_0000, 6'd0);
        add_code(MODE_FINISH, 32'hFFFF_FFFF, 6'd32);

        // Random codes, mostly in range, with finishes and overlong lengths mixed in.
        while (made < RANDOM_CODES) begin
            sel = $urandom_range(0, 99);
            if (sel < 6) begin
                add_code(MODE_FINISH, $urandom, LEN_W'($urandom_range(0, 63)));
                made++;
            end else if (sel < 10) begin
                add_code(MODE_APPEND, $urandom, 6'd0);
            end else if (sel < 22) begin
                add_code(MODE_APPEND, $urandom, LEN_W'($urandom_range(33, 63)));
                made++;
            end else begin
                add_code(MODE_APPEND, $urandom, LEN_W'($urandom_range(1, 32)));
                made++;
            end
        end
        add_code(MODE_FINISH, $urandom, 6'd5);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_codes.size() > 0 || drv_valid) @(posedge i_clk);
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d code and finish transactions, checked %0d results in %0d chunks.",
                 codes_accepted, words_checked, chunks_seen);
        $display("Included empty finish, zero-length, overlong, exact-fill codes and a long stall.");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results still expected.",
                     mismatches, expected_words.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/vlcp_pkg.sv
rtl/vlcp_in_if.sv
rtl/vlcp_out_if.sv
rtl/vlcp_emitter.sv
rtl/variable_length_code_chunk_packer.sv
dv/variable_length_code_chunk_packer_test.sv
